### rtl/core/pidl_pkg.sv
package pidl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int TDATA_W   = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### rtl/core/pidl_mem.sv
module pidl_mem
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/positional_insert_delete_list.sv
// channel | direction | tdata (low bit up)                      | tuser
// s_      | in        | value[31:0], position[36:32], zero fill | cmd[1:0]
// m_      | out       | read_value[31:0], count[36:32], zero fill | status[1:0]
//
// an insert moves each entry from the tail down to the position up by one, then
// writes the value; a delete moves each entry after the position down by one; a
// read is one ram read; each moved entry is one read then one write of the list ram
// reset (aresetn low) empties the list; ram contents are not cleared
// a new item is taken while the previous result still waits on m_tready;
// a finished item holds in the sequencer until the output register is free
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // value, position
    input  logic [CMD_W-1:0]   s_tuser,  // cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // read_value, count
    output logic [STAT_W-1:0]  m_tuser   // status
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CMPW-1:0]   idx_reg, idx_next;
    logic [CMPW-1:0]   pos_reg, pos_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [DATA_W-1:0] rdv_reg, rdv_next;
    logic              mv_reg, mv_next;
    logic [DATA_W-1:0] mdata_reg, mdata_next;
    logic [CNT_OUT_W-1:0] mcnt_reg, mcnt_next;
    logic [STAT_W-1:0] mstat_reg, mstat_next;

    logic [CMPW-1:0]   cnt_ext, in_pos, idx_adj;
    logic              out_free;
    mem_ctl_t          mctl;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;

    assign cnt_ext  = CMPW'(count_reg);
    assign in_pos   = CMPW'(s_tdata[DATA_W +: POS_W]);
    assign idx_adj  = (cmd_reg == CMD_INSERT) ? idx_reg - 1'b1 : idx_reg + 1'b1;
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    pidl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk    (aclk),
        .ctl     (mctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        value_next = value_reg;
        stat_next  = stat_reg;
        rdv_next   = rdv_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mcnt_next  = mcnt_reg;
        mstat_next = mstat_reg;
        mctl       = '0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_data;
        rd_addr    = (cmd_reg == CMD_READ) ? idx_reg[AW-1:0] : idx_adj[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    value_next = s_tdata[DATA_W-1:0];
                    pos_next   = in_pos;
                    rdv_next   = '0;
                    stat_next  = ST_RANGE;
                    state_next = S_FIN;
                    case (s_tuser)
                        CMD_INSERT: begin
                            if (cnt_ext >= CMPW'(DEPTH)) begin
                                stat_next = ST_FULL;
                            end else if (in_pos <= cnt_ext) begin
                                stat_next  = ST_DONE;
                                count_next = count_reg + 1'b1;
                                idx_next   = cnt_ext;
                                state_next = (in_pos == cnt_ext) ? S_PUT : S_RD;
                            end
                        end
                        CMD_DELETE: begin
                            if (count_reg == '0) begin
                                stat_next = ST_EMPTY;
                            end else if (in_pos < cnt_ext) begin
                                stat_next  = ST_DONE;
                                count_next = count_reg - 1'b1;
                                idx_next   = in_pos;
                                if (in_pos + 1'b1 < cnt_ext) begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (count_reg == '0) begin
                                stat_next = ST_EMPTY;
                            end else if (in_pos < cnt_ext) begin
                                stat_next  = ST_DONE;
                                idx_next   = in_pos;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            stat_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RD: begin
                mctl.rd_en = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                case (cmd_reg)
                    CMD_INSERT: begin
                        mctl.wr_en = 1'b1;
                        idx_next   = idx_adj;
                        state_next = (idx_adj == pos_reg) ? S_PUT : S_RD;
                    end
                    CMD_DELETE: begin
                        mctl.wr_en = 1'b1;
                        idx_next   = idx_adj;
                        state_next = (idx_adj < cnt_ext) ? S_RD : S_FIN;
                    end
                    default: begin
                        rdv_next   = rd_data;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_PUT: begin
                mctl.wr_en = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = value_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mdata_next = rdv_reg;
                    mcnt_next  = cnt_ext[CNT_OUT_W-1:0];
                    mstat_next = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        stat_reg  <= stat_next;
        rdv_reg   <= rdv_next;
        mdata_reg <= mdata_next;
        mcnt_reg  <= mcnt_next;
        mstat_reg <= mstat_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(TDATA_W - DATA_W - CNT_OUT_W){1'b0}}, mcnt_reg, mdata_reg};
    assign m_tuser  = mstat_reg;

endmodule
